### rtl/core/coordinate_message_parser_unit_assert.svh
// Assertion macros for the coordinate message parser checker.
// Each macro expects aclk in scope, and the first two also aresetn; no other dependencies.
`ifndef COORDINATE_MESSAGE_PARSER_UNIT_ASSERT_SVH
`define COORDINATE_MESSAGE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CMPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define CMPU_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cmp_pkg.sv
// Shared types, character codes and fixed-point constants for the coordinate
// message parser. No dependencies.
package cmp_pkg;

    localparam int FRAC_DIGITS = 3;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int NUM_FIELDS  = 4;

    function automatic longint unsigned pow10(input int n);
        longint unsigned r;
        r = 1;
        for (int k = 0; k < n; k++) begin
            r = r * 10;
        end
        return r;
    endfunction

    localparam longint unsigned UNIT_FULL = pow10(FRAC_DIGITS);
    localparam int UNIT_W = $clog2(UNIT_FULL + 1);
    localparam int ADD_W  = $clog2(9 * UNIT_FULL + 1);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int SUM_W  = ((VALUE_WIDTH + 4 > ADD_W) ? VALUE_WIDTH + 4 : ADD_W) + 1;

    localparam logic [UNIT_W-1:0]      UNIT       = UNIT_W'(UNIT_FULL);
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX  = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] MAX_DIV10  = VALUE_MAX / 10;
    localparam logic [VALUE_WIDTH-1:0] VALUE_INIT = VALUE_WIDTH'(UNIT_FULL);

    // Weight of the next fraction digit, indexed by fraction digits still counted.
    typedef logic [FRAC_DIGITS:0][UNIT_W-1:0] weight_tab_t;

    function automatic weight_tab_t build_weights();
        weight_tab_t     w;
        longint unsigned p;
        p    = 1;
        w[0] = '0;
        for (int k = 1; k <= FRAC_DIGITS; k++) begin
            w[k] = UNIT_W'(p);
            p    = p * 10;
        end
        return w;
    endfunction

    localparam weight_tab_t FRAC_WEIGHT = build_weights();

    // ASCII codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field slots
    localparam logic [1:0] FLD_X       = 2'd0;
    localparam logic [1:0] FLD_Y       = 2'd1;
    localparam logic [1:0] FLD_Z       = 2'd2;
    localparam logic [1:0] FLD_HEADING = 2'd3;

    typedef enum logic [3:0] {
        PH_WAIT       = 4'd0,
        PH_NAME       = 4'd1,
        PH_COLON      = 4'd2,
        PH_FIRST      = 4'd3,
        PH_INT        = 4'd4,
        PH_FRAC_FIRST = 4'd5,
        PH_FRAC       = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        VOP_HOLD  = 2'd0,
        VOP_FIRST = 2'd1,
        VOP_INT   = 2'd2,
        VOP_FRAC  = 2'd3
    } vop_t;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_lt;
        logic       is_gt;
        logic       is_colon;
        logic       is_comma;
        logic       is_dot;
        logic       is_name;
        logic [1:0] name_field;
    } char_class_t;

    typedef logic [NUM_FIELDS-1:0][VALUE_WIDTH-1:0] value_set_t;

endpackage

### rtl/core/cmp_char_class.sv
// Character classifier: decodes one ASCII code into token flags.
// Depends on cmp_pkg.
module cmp_char_class (
    input  logic [7:0]           char_code,
    output cmp_pkg::char_class_t cls
);

    always_comb begin
        cls            = '0;
        cls.is_digit   = (char_code >= cmp_pkg::CH_ZERO) && (char_code <= cmp_pkg::CH_NINE);
        cls.digit      = cls.is_digit ? 4'(char_code - cmp_pkg::CH_ZERO) : 4'd0;
        cls.is_lt      = (char_code == cmp_pkg::CH_LT);
        cls.is_gt      = (char_code == cmp_pkg::CH_GT);
        cls.is_colon   = (char_code == cmp_pkg::CH_COLON);
        cls.is_comma   = (char_code == cmp_pkg::CH_COMMA);
        cls.is_dot     = (char_code == cmp_pkg::CH_DOT);
        unique case (char_code)
            cmp_pkg::CH_X: begin
                cls.is_name    = 1'b1;
                cls.name_field = cmp_pkg::FLD_X;
            end
            cmp_pkg::CH_Y: begin
                cls.is_name    = 1'b1;
                cls.name_field = cmp_pkg::FLD_Y;
            end
            cmp_pkg::CH_Z: begin
                cls.is_name    = 1'b1;
                cls.name_field = cmp_pkg::FLD_Z;
            end
            cmp_pkg::CH_A: begin
                cls.is_name    = 1'b1;
                cls.name_field = cmp_pkg::FLD_HEADING;
            end
            default: begin
                cls.is_name    = 1'b0;
                cls.name_field = cmp_pkg::FLD_X;
            end
        endcase
    end

endmodule

### rtl/core/cmp_value_step.sv
// Saturating fixed-point digit accumulator: d*unit, value*10 + d*unit, or value + d*weight.
// Depends on cmp_pkg.
module cmp_value_step (
    input  cmp_pkg::vop_t                   op,
    input  logic [cmp_pkg::VALUE_WIDTH-1:0] value_in,
    input  logic [3:0]                      digit,
    input  logic [cmp_pkg::CNT_W-1:0]       frac_cnt,
    output logic [cmp_pkg::VALUE_WIDTH-1:0] value_out
);

    logic [cmp_pkg::SUM_W-1:0]  times10;
    logic [cmp_pkg::SUM_W-1:0]  base;
    logic [cmp_pkg::SUM_W-1:0]  sum;
    logic [cmp_pkg::UNIT_W-1:0] weight;
    logic [cmp_pkg::ADD_W-1:0]  addend;
    logic                       mul_sat;

    always_comb begin
        times10 = cmp_pkg::SUM_W'({value_in, 3'b000}) + cmp_pkg::SUM_W'({value_in, 1'b0});
        mul_sat = 1'b0;
        case (op)
            cmp_pkg::VOP_FIRST: begin
                base   = '0;
                weight = cmp_pkg::UNIT;
            end
            cmp_pkg::VOP_INT: begin
                base    = times10;
                weight  = cmp_pkg::UNIT;
                mul_sat = (value_in > cmp_pkg::MAX_DIV10);
            end
            cmp_pkg::VOP_FRAC: begin
                base   = cmp_pkg::SUM_W'(value_in);
                weight = cmp_pkg::FRAC_WEIGHT[frac_cnt];
            end
            default: begin
                base   = cmp_pkg::SUM_W'(value_in);
                weight = '0;
            end
        endcase
        addend = cmp_pkg::ADD_W'(digit) * cmp_pkg::ADD_W'(weight);
        sum    = base + cmp_pkg::SUM_W'(addend);
        if (mul_sat || (sum > cmp_pkg::SUM_W'(cmp_pkg::VALUE_MAX))) begin
            value_out = cmp_pkg::VALUE_MAX;
        end else begin
            value_out = sum[cmp_pkg::VALUE_WIDTH-1:0];
        end
    end

endmodule

### rtl/core/cmp_parser.sv
// Parse state machine and field registers; one character per step.
// Depends on cmp_pkg, cmp_char_class and cmp_value_step.
module cmp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          char_code,
    input  logic                last,
    output cmp_pkg::value_set_t values_next,
    output logic                error_next
);

    cmp_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                      sel_reg, sel_next;
    logic [cmp_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            error_reg;
    cmp_pkg::value_set_t             values_reg;
    cmp_pkg::char_class_t            cls;
    cmp_pkg::vop_t                   vop;
    logic [cmp_pkg::VALUE_WIDTH-1:0] step_value;

    cmp_char_class u_class (
        .char_code (char_code),
        .cls       (cls)
    );

    cmp_value_step u_step (
        .op        (vop),
        .value_in  (values_reg[sel_reg]),
        .digit     (cls.digit),
        .frac_cnt  (cnt_reg),
        .value_out (step_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            phase_reg  <= cmp_pkg::PH_WAIT;
            sel_reg    <= cmp_pkg::FLD_X;
            cnt_reg    <= '0;
            error_reg  <= 1'b0;
            values_reg <= {cmp_pkg::NUM_FIELDS{cmp_pkg::VALUE_INIT}};
        end else if (step) begin
            phase_reg  <= phase_next;
            sel_reg    <= sel_next;
            cnt_reg    <= cnt_next;
            error_reg  <= error_next;
            values_reg <= values_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        error_next = error_reg;
        vop        = cmp_pkg::VOP_HOLD;
        unique case (phase_reg) inside
            cmp_pkg::PH_WAIT: begin
                if (cls.is_lt) begin
                    phase_next = cmp_pkg::PH_NAME;
                end
            end
            cmp_pkg::PH_NAME: begin
                if (cls.is_name) begin
                    sel_next   = cls.name_field;
                    phase_next = cmp_pkg::PH_COLON;
                end else begin
                    phase_next = cmp_pkg::PH_ERROR;
                    error_next = 1'b1;
                end
            end
            cmp_pkg::PH_COLON: begin
                if (cls.is_colon) begin
                    phase_next = cmp_pkg::PH_FIRST;
                end else begin
                    phase_next = cmp_pkg::PH_ERROR;
                    error_next = 1'b1;
                end
            end
            cmp_pkg::PH_FIRST: begin
                if (cls.is_digit) begin
                    vop        = cmp_pkg::VOP_FIRST;
                    phase_next = cmp_pkg::PH_INT;
                end else begin
                    phase_next = cmp_pkg::PH_ERROR;
                    error_next = 1'b1;
                end
            end
            cmp_pkg::PH_INT: begin
                if (cls.is_digit) begin
                    vop = cmp_pkg::VOP_INT;
                end else if (cls.is_dot) begin
                    cnt_next   = cmp_pkg::CNT_W'(cmp_pkg::FRAC_DIGITS);
                    phase_next = cmp_pkg::PH_FRAC_FIRST;
                end else if (cls.is_comma) begin
                    phase_next = cmp_pkg::PH_NAME;
                end else if (cls.is_gt) begin
                    phase_next = cmp_pkg::PH_DONE;
                end else begin
                    phase_next = cmp_pkg::PH_ERROR;
                    error_next = 1'b1;
                end
            end
            cmp_pkg::PH_FRAC_FIRST, cmp_pkg::PH_FRAC: begin
                if (cls.is_digit) begin
                    // Digits past the last weighted position add zero.
                    vop        = cmp_pkg::VOP_FRAC;
                    cnt_next   = (cnt_reg == '0) ? '0 : cnt_reg - cmp_pkg::CNT_W'(1);
                    phase_next = cmp_pkg::PH_FRAC;
                end else if ((phase_reg == cmp_pkg::PH_FRAC) && cls.is_comma) begin
                    phase_next = cmp_pkg::PH_NAME;
                end else if ((phase_reg == cmp_pkg::PH_FRAC) && cls.is_gt) begin
                    phase_next = cmp_pkg::PH_DONE;
                end else begin
                    phase_next = cmp_pkg::PH_ERROR;
                    error_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < cmp_pkg::NUM_FIELDS; i++) begin
            values_next[i] = ((vop != cmp_pkg::VOP_HOLD) && (sel_reg == 2'(i)))
                           ? step_value : values_reg[i];
        end
    end

endmodule

### rtl/core/coordinate_message_parser_unit.sv
// Result: m_tvalid rises from the result register, loaded when the character marked by
// s_tlast is parsed (the parse step runs while the character sits in the input register).
// Throughput: 1 character per cycle, set by the combinational parse step between the two
// registers; the input holds only while a result in the result register waits on m_tready.
// Reset (aresetn low, synchronous): parser returns to waiting for '<', fields read 1.000,
// error clears, input and result registers empty.
//
// Top level of the coordinate message parser. Depends on cmp_pkg and cmp_parser.
module coordinate_message_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // last
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] x_value, [63:32] y_value,
                                    // [95:64] z_value, [127:96] heading_value
    output logic         m_tuser    // [0] parse_error
);

    localparam int TDATA_W = cmp_pkg::NUM_FIELDS * cmp_pkg::OUT_W;

    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg;
    logic                out_error_reg;
    logic                fire;
    logic                out_free;
    cmp_pkg::value_set_t values_next;
    logic                error_next;
    logic [TDATA_W-1:0]  packed_values;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // Parse the held character when its result, if any, has somewhere to go.
    assign fire     = in_valid_reg && out_free;
    // Take a new character whenever the input register empties this cycle.
    assign s_tready = !in_valid_reg || fire;

    // Input register: hold one character ahead of the parser.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cmp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (fire),
        .char_code   (in_char_reg),
        .last        (in_last_reg),
        .values_next (values_next),
        .error_next  (error_next)
    );

    // Pack fields lowest first; each value carries its low OUT_W bits.
    always_comb begin
        for (int i = 0; i < cmp_pkg::NUM_FIELDS; i++) begin
            packed_values[i*cmp_pkg::OUT_W +: cmp_pkg::OUT_W] = cmp_pkg::OUT_W'(values_next[i]);
        end
    end

    // Result register: load on the last character, drop once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            out_data_reg  <= packed_values;
            out_error_reg <= error_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_error_reg;

endmodule

### rtl/core/coordinate_message_parser_unit_checker.sv
// Port-level checker for the coordinate message parser, bound to the top level.
// Depends on coordinate_message_parser_unit_assert.svh.
`include "coordinate_message_parser_unit_assert.svh"

module coordinate_message_parser_unit_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    logic       last_in;
    logic       result_out;
    logic [1:0] pending_reg, pending_next;

    assign last_in    = s_tvalid && s_tready && s_tlast;
    assign result_out = m_tvalid && m_tready;

    // Count message ends taken but not yet delivered as results.
    always_comb begin
        pending_next = pending_reg + 2'(last_in) - 2'(result_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `CMPU_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `CMPU_ASSERT_NOW(a_result_has_cause, result_out, pending_reg != 2'd0, "result without a preceding last character")
    `CMPU_ASSERT_NOW(a_pending_bound, 1'b1, pending_reg <= 2'd2, "more than two messages in flight")
    `CMPU_ASSERT_NOW(a_ready_only_blocked_by_output, !s_tready, m_tvalid && !m_tready, "input stalled while result side free")
    `CMPU_ASSERT_RESET(a_reset_clears_result, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind coordinate_message_parser_unit coordinate_message_parser_unit_checker u_checker (.*);
